FILE: rtl/lsrc_pkg.sv
package lsrc_pkg;

    localparam int COORD_BITS = 16;
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LEFT   = 3'd0,
        REG_TOP    = 3'd1,
        REG_RIGHT  = 3'd2,
        REG_BOTTOM = 3'd3
    } reg_idx_t;

endpackage

FILE: rtl/lsrc_ifs.sv
interface lsrc_in_if #(parameter int W = lsrc_pkg::COORD_BITS);
    logic valid;
    logic ready;
    logic signed [W-1:0] p1_x;
    logic signed [W-1:0] p1_y;
    logic signed [W-1:0] p2_x;
    logic signed [W-1:0] p2_y;
    modport source (output valid, p1_x, p1_y, p2_x, p2_y, input ready);
    modport sink (input valid, p1_x, p1_y, p2_x, p2_y, output ready);
endinterface

interface lsrc_out_if #(parameter int W = lsrc_pkg::COORD_BITS);
    logic valid;
    logic ready;
    logic visible;
    logic signed [W-1:0] out1_x;
    logic signed [W-1:0] out1_y;
    logic signed [W-1:0] out2_x;
    logic signed [W-1:0] out2_y;
    modport source (output valid, visible, out1_x, out1_y, out2_x, out2_y, input ready);
    modport sink (input valid, visible, out1_x, out1_y, out2_x, out2_y, output ready);
endinterface

interface lsrc_cfg_if #(parameter int W = lsrc_pkg::COORD_BITS);
    logic valid;
    logic ready;
    logic [lsrc_pkg::CFG_IDX_BITS-1:0] index;
    logic [W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/line_segment_rect_clip.sv
// line segment clipper against a configured rectangle
// seg_in takes one segment word (p1_x, p1_y, p2_x, p2_y) per cycle; seg_out
// gives one result word (visible and two clipped endpoints) per segment, in
// order. cfg writes rect_left/top/right/bottom at index 0..3 and is always
// ready; a write at any other index is dropped. write it only while idle.
// the path from accept to result valid runs through one prep stage, one
// multiplier stage, one stage for each quotient bit of the four restoring
// dividers, one rounding and range stage and the output register.
// throughput is one segment per cycle while the output is not stalled.
// the whole pipeline advances when the output register is empty or taken;
// while the receiver stalls a full output register, seg_in.ready is low and
// every stage holds, so nothing is lost or repeated.
// reset clears all valid bits and sets the rectangle to zero; there is no
// clearing pass, the block takes segments right after reset.
// a not visible result carries all four coordinates at zero.
module line_segment_rect_clip #(
    parameter int COORD_BITS = lsrc_pkg::COORD_BITS
) (
    input logic clk,
    input logic rst_n,
    lsrc_in_if.sink seg_in,
    lsrc_out_if.source seg_out,
    lsrc_cfg_if.sink cfg
);
    localparam int W = COORD_BITS;

    typedef struct packed {
        logic ok;
        logic neg;
        logic pos;
        logic [W-1:0] d;
        logic [W-1:0] um;
        logic [W-1:0] m;
        logic signed [W-1:0] b1;
    } prep_t;

    typedef struct packed {
        logic ok;
        logic neg;
        logic pos;
        logic [W-1:0] d;
        logic signed [W-1:0] b1;
        logic [W-1:0] r;
        logic [W-1:0] q;
        logic [W-1:0] low;
    } lane_t;

    typedef struct packed {
        logic signed [W-1:0] x1;
        logic signed [W-1:0] y1;
        logic signed [W-1:0] x2;
        logic signed [W-1:0] y2;
        logic in1;
        logic in2;
    } item_t;

    logic signed [W-1:0] left_reg, top_reg, right_reg, bottom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            top_reg <= '0;
            right_reg <= '0;
            bottom_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                lsrc_pkg::REG_LEFT: left_reg <= cfg.data;
                lsrc_pkg::REG_TOP: top_reg <= cfg.data;
                lsrc_pkg::REG_RIGHT: right_reg <= cfg.data;
                lsrc_pkg::REG_BOTTOM: bottom_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    logic adv;
    logic out_valid_reg;
    assign adv = !out_valid_reg || seg_out.ready;
    assign seg_in.ready = adv;

    function automatic prep_t prep(input logic signed [W-1:0] a1, input logic signed [W-1:0] b1,
                                   input logic signed [W-1:0] a2, input logic signed [W-1:0] b2,
                                   input logic signed [W-1:0] e);
        logic signed [W:0] da;
        logic signed [W:0] db;
        logic signed [W:0] u;
        logic signed [W:0] ada;
        logic signed [W:0] adb;
        logic signed [W:0] au;
        prep_t p;
        da = {a2[W-1], a2} - {a1[W-1], a1};
        db = {b2[W-1], b2} - {b1[W-1], b1};
        u = {e[W-1], e} - {a1[W-1], a1};
        ada = (da < 0) ? -da : da;
        adb = (db < 0) ? -db : db;
        au = (u < 0) ? -u : u;
        p.ok = (da != 0) && ((da > 0) ? (u >= 0 && u <= da) : (u <= 0 && u >= da));
        p.neg = db < 0;
        p.pos = db > 0;
        p.d = ada[W-1:0];
        p.um = au[W-1:0];
        p.m = adb[W-1:0];
        p.b1 = b1;
        return p;
    endfunction

    function automatic lane_t div_step(input lane_t l);
        logic [W:0] t;
        logic [W:0] diff;
        logic ge;
        lane_t n;
        n = l;
        t = {l.r, l.low[W-1]};
        diff = t - {1'b0, l.d};
        ge = t >= {1'b0, l.d};
        n.r = ge ? diff[W-1:0] : t[W-1:0];
        n.q = {l.q[W-2:0], ge};
        n.low = {l.low[W-2:0], 1'b0};
        return n;
    endfunction

    // prep stage
    prep_t s1_lane_reg [4];
    item_t s1_item_reg;
    logic s1_valid_reg;
    prep_t s1_lane_next [4];
    item_t s1_item_next;

    always_comb
    begin
        s1_lane_next[0] = prep(seg_in.p1_x, seg_in.p1_y, seg_in.p2_x, seg_in.p2_y, left_reg);
        s1_lane_next[1] = prep(seg_in.p1_x, seg_in.p1_y, seg_in.p2_x, seg_in.p2_y, right_reg);
        s1_lane_next[2] = prep(seg_in.p1_y, seg_in.p1_x, seg_in.p2_y, seg_in.p2_x, top_reg);
        s1_lane_next[3] = prep(seg_in.p1_y, seg_in.p1_x, seg_in.p2_y, seg_in.p2_x, bottom_reg);
        s1_item_next.x1 = seg_in.p1_x;
        s1_item_next.y1 = seg_in.p1_y;
        s1_item_next.x2 = seg_in.p2_x;
        s1_item_next.y2 = seg_in.p2_y;
        s1_item_next.in1 = seg_in.p1_x >= left_reg && seg_in.p1_x < right_reg
                           && seg_in.p1_y >= top_reg && seg_in.p1_y < bottom_reg;
        s1_item_next.in2 = seg_in.p2_x >= left_reg && seg_in.p2_x < right_reg
                           && seg_in.p2_y >= top_reg && seg_in.p2_y < bottom_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= seg_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_lane_reg <= s1_lane_next;
            s1_item_reg <= s1_item_next;
        end
    end

    // multiplier stage (index 0) then one stage per quotient bit
    lane_t dv_reg [W+1][4];
    item_t it_reg [W+1];
    logic [W:0] vl_reg;
    logic [2*W-1:0] prod [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vl_reg <= '0;
        else if (adv)
            vl_reg <= {vl_reg[W-1:0], s1_valid_reg};
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            prod[k] = (2*W)'(s1_lane_reg[k].m) * (2*W)'(s1_lane_reg[k].um);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                dv_reg[0][k].ok <= s1_lane_reg[k].ok;
                dv_reg[0][k].neg <= s1_lane_reg[k].neg;
                dv_reg[0][k].pos <= s1_lane_reg[k].pos;
                dv_reg[0][k].d <= s1_lane_reg[k].d;
                dv_reg[0][k].b1 <= s1_lane_reg[k].b1;
                dv_reg[0][k].r <= prod[k][2*W-1:W];
                dv_reg[0][k].q <= '0;
                dv_reg[0][k].low <= prod[k][W-1:0];
                for (int i = 1; i <= W; i++)
                    dv_reg[i][k] <= div_step(dv_reg[i-1][k]);
            end
            it_reg[0] <= s1_item_reg;
            for (int i = 1; i <= W; i++)
                it_reg[i] <= it_reg[i-1];
        end
    end

    // rounding toward zero and range test
    logic [3:0] hit_reg;
    logic signed [W-1:0] c_reg [4];
    item_t fin_item_reg;
    logic fin_valid_reg;
    logic [3:0] hit_next;
    logic signed [W-1:0] c_next [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            logic signed [W:0] base;
            lane_t l;
            l = dv_reg[W][k];
            base = l.neg ? ({l.b1[W-1], l.b1} - {1'b0, l.q})
                         : ({l.b1[W-1], l.b1} + {1'b0, l.q});
            if (l.r != '0)
            begin
                if (l.pos && base < 0)
                    base = base + $signed((W+1)'(1));
                else if (l.neg && base > 0)
                    base = base - $signed((W+1)'(1));
            end
            c_next[k] = base[W-1:0];
        end
        hit_next[0] = dv_reg[W][0].ok && c_next[0] >= top_reg && c_next[0] <= bottom_reg;
        hit_next[1] = dv_reg[W][1].ok && c_next[1] >= top_reg && c_next[1] <= bottom_reg;
        hit_next[2] = dv_reg[W][2].ok && c_next[2] >= left_reg && c_next[2] <= right_reg;
        hit_next[3] = dv_reg[W][3].ok && c_next[3] >= left_reg && c_next[3] <= right_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_valid_reg <= 1'b0;
        else if (adv)
            fin_valid_reg <= vl_reg[W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg <= hit_next;
            c_reg <= c_next;
            fin_item_reg <= it_reg[W];
        end
    end

    // pick the first two crossings in edge order
    logic signed [W-1:0] cx [4];
    logic signed [W-1:0] cy [4];
    logic signed [W-1:0] ax, ay, bx, by;
    logic [2:0] n_hit;
    logic vis_next;
    logic signed [W-1:0] o1x_next, o1y_next, o2x_next, o2y_next;

    always_comb
    begin
        cx[0] = left_reg;   cy[0] = c_reg[0];
        cx[1] = right_reg;  cy[1] = c_reg[1];
        cx[2] = c_reg[2];   cy[2] = top_reg;
        cx[3] = c_reg[3];   cy[3] = bottom_reg;
        ax = '0; ay = '0; bx = '0; by = '0;
        n_hit = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (hit_reg[k])
            begin
                if (n_hit == 3'd0)
                begin
                    ax = cx[k];
                    ay = cy[k];
                end
                else if (n_hit == 3'd1)
                begin
                    bx = cx[k];
                    by = cy[k];
                end
                n_hit = n_hit + 3'd1;
            end
        end
        vis_next = 1'b0;
        o1x_next = '0; o1y_next = '0; o2x_next = '0; o2y_next = '0;
        if (fin_item_reg.in1 && fin_item_reg.in2)
        begin
            vis_next = 1'b1;
            o1x_next = fin_item_reg.x1; o1y_next = fin_item_reg.y1;
            o2x_next = fin_item_reg.x2; o2y_next = fin_item_reg.y2;
        end
        else if (n_hit != 3'd0 && (fin_item_reg.in1 || fin_item_reg.in2))
        begin
            vis_next = 1'b1;
            o1x_next = fin_item_reg.in1 ? fin_item_reg.x1 : fin_item_reg.x2;
            o1y_next = fin_item_reg.in1 ? fin_item_reg.y1 : fin_item_reg.y2;
            o2x_next = ax; o2y_next = ay;
        end
        else if (n_hit >= 3'd2)
        begin
            vis_next = 1'b1;
            o1x_next = ax; o1y_next = ay;
            o2x_next = bx; o2y_next = by;
        end
    end

    // output register
    logic vis_reg;
    logic signed [W-1:0] o1x_reg, o1y_reg, o2x_reg, o2y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= fin_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vis_reg <= vis_next;
            o1x_reg <= o1x_next;
            o1y_reg <= o1y_next;
            o2x_reg <= o2x_next;
            o2y_reg <= o2y_next;
        end
    end

    assign seg_out.valid = out_valid_reg;
    assign seg_out.visible = vis_reg;
    assign seg_out.out1_x = o1x_reg;
    assign seg_out.out1_y = o1y_reg;
    assign seg_out.out2_x = o2x_reg;
    assign seg_out.out2_y = o2y_reg;

    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        seg_in.ready == (!seg_out.valid || seg_out.ready))
        else $error("input ready does not track output stall");

    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (seg_out.valid && !seg_out.visible) |->
        (seg_out.out1_x == '0 && seg_out.out1_y == '0
         && seg_out.out2_x == '0 && seg_out.out2_y == '0))
        else $error("hidden segment with nonzero coordinates");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (seg_in.valid && seg_in.ready) |=> s1_valid_reg)
        else $error("accepted segment lost at prep stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(vl_reg) && $stable(fin_valid_reg) && $stable(s1_valid_reg)))
        else $error("pipeline moved during stall");

endmodule
